// File: rtl/fsr_pkg.sv
// fsr_pkg: shared types and constants for the field similarity ratio block
// used by fsr_ctrl, fsr_dp, field_similarity_ratio and fsr_checker
// no dependencies
package fsr_pkg;

	// fixed field widths
	localparam int DATA_W      = 32;
	localparam int COMP_W      = DATA_W + 1;
	localparam int S_TDATA_W   = 2 * DATA_W;
	localparam int Q_FRAC      = 16;
	localparam int SIM_W       = Q_FRAC + 1;
	localparam int M_TDATA_W   = 24;
	localparam int CFG_INDEX_W = 1;
	localparam int STEP_W      = $clog2(Q_FRAC);

	// parameter defaults
	localparam int SAMPLE_WIDTH_DEF     = 32;
	localparam int LOG2_MAX_SAMPLES_DEF = 24;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_RANGE_LOW  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_RANGE_HIGH = 1'b1;

	// register reset values
	localparam logic signed [DATA_W-1:0] RANGE_LOW_RST  = 32'sd0;
	localparam logic signed [DATA_W-1:0] RANGE_HIGH_RST = 32'sd255;

	// 1.0 in unsigned Q1.16
	localparam logic [SIM_W-1:0] Q_ONE = 17'h10000;

	// controller states
	typedef enum logic [1:0] {
		ST_RUN,
		ST_FLUSH,
		ST_DIV,
		ST_DONE
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load_s1;
		logic acc;
		logic div_load;
		logic div_step;
		logic out_load;
	} cmd_t;

endpackage

// File: rtl/fsr_ctrl.sv
// fsr_ctrl: controller state machine for the field similarity ratio block
// depends on fsr_pkg; drives fsr_dp through fsr_pkg::cmd_t
module fsr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	input  logic          s_tlast,
	output logic          s_tready,
	input  logic          m_tready,
	output logic          m_tvalid,
	output fsr_pkg::cmd_t cmd
);

	fsr_pkg::state_t           state_q, state_d;
	logic [fsr_pkg::STEP_W-1:0] step_q, step_d;
	logic                      valid_s1;
	logic                      m_tvalid_q;
	logic                      div_busy_q;
	logic                      accept;
	logic                      out_free;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;

	// state, step counter, stage one valid and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= fsr_pkg::ST_RUN;
			step_q     <= '0;
			valid_s1   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			step_q   <= step_d;
			valid_s1 <= accept;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// next state and commands
	always_comb begin
		state_d      = state_q;
		step_d       = step_q;
		s_tready     = 1'b0;
		cmd          = '0;
		cmd.acc      = valid_s1;
		case (state_q)
			fsr_pkg::ST_RUN: begin
				s_tready = 1'b1;
				if (s_tvalid && s_tlast) begin
					state_d = fsr_pkg::ST_FLUSH;
				end
			end
			// last pair is being added into the sums
			fsr_pkg::ST_FLUSH: begin
				state_d = fsr_pkg::ST_DIV;
			end
			// first cycle loads the divider, then one quotient bit a cycle
			fsr_pkg::ST_DIV: begin
				if (!div_busy_q) begin
					cmd.div_load = 1'b1;
				end else begin
					cmd.div_step = 1'b1;
					step_d       = step_q + 1'b1;
					if (step_q == fsr_pkg::STEP_W'(fsr_pkg::Q_FRAC - 1)) begin
						step_d  = '0;
						state_d = fsr_pkg::ST_DONE;
					end
				end
			end
			fsr_pkg::ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = fsr_pkg::ST_RUN;
				end
			end
			default: begin
				state_d = fsr_pkg::ST_RUN;
			end
		endcase
		cmd.load_s1 = s_tvalid && s_tready;
	end

	// marks that the divider has been loaded for this run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
		end else if (cmd.div_load) begin
			div_busy_q <= 1'b1;
		end else if (state_d == fsr_pkg::ST_DONE) begin
			div_busy_q <= 1'b0;
		end
	end

endmodule

// File: rtl/fsr_dp.sv
// fsr_dp: datapath with range registers, clamp stage, saturating sums,
// bit-serial Q0.16 divider and result register; depends on fsr_pkg
module fsr_dp #(
	parameter int SAMPLE_WIDTH     = fsr_pkg::SAMPLE_WIDTH_DEF,
	parameter int LOG2_MAX_SAMPLES = fsr_pkg::LOG2_MAX_SAMPLES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  fsr_pkg::cmd_t                     cmd,
	input  logic                              cfg_we,
	input  logic [fsr_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [fsr_pkg::DATA_W-1:0]        cfg_wdata,
	input  logic [fsr_pkg::DATA_W-1:0]        sample_a,
	input  logic [fsr_pkg::DATA_W-1:0]        sample_b,
	output logic [fsr_pkg::SIM_W-1:0]         similarity,
	output logic                              zero_denominator
);

	localparam int SUM_W = SAMPLE_WIDTH + 1 + LOG2_MAX_SAMPLES;
	localparam int ADD_W = ((SUM_W > fsr_pkg::COMP_W) ? SUM_W : fsr_pkg::COMP_W) + 1;
	localparam int EXT_W = fsr_pkg::DATA_W + 1;
	localparam int DIF_W = fsr_pkg::DATA_W + 2;
	localparam logic [ADD_W-1:0] SUM_MAX = {{(ADD_W - SUM_W){1'b0}}, {SUM_W{1'b1}}};

	logic signed [fsr_pkg::DATA_W-1:0] range_low_q, range_high_q;
	logic signed [EXT_W-1:0]           a_ext, b_ext, low_ext, high_ext;
	logic signed [EXT_W-1:0]           a_cl, b_cl, lo_v, hi_v;
	logic signed [DIF_W-1:0]           dif_small, dif_large;
	logic [fsr_pkg::COMP_W-1:0]        comp_small_s1, comp_large_s1;
	logic [SUM_W-1:0]                  sum_small_q, sum_large_q;
	logic [ADD_W-1:0]                  add_small, add_large;
	logic [SUM_W-1:0]                  rem_q, den_q;
	logic [fsr_pkg::Q_FRAC-1:0]        quot_q;
	logic                              one_q, zero_q;
	logic [SUM_W:0]                    rem_sh;
	logic                              rem_ge;
	logic [SUM_W:0]                    rem_sub;
	logic [fsr_pkg::SIM_W-1:0]         sim_q;
	logic                              zero_out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q  <= fsr_pkg::RANGE_LOW_RST;
			range_high_q <= fsr_pkg::RANGE_HIGH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				fsr_pkg::REG_RANGE_LOW:  range_low_q  <= cfg_wdata;
				fsr_pkg::REG_RANGE_HIGH: range_high_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// sign extend the low sample bits and clamp into the range
	always_comb begin
		a_ext    = {{(EXT_W - SAMPLE_WIDTH){sample_a[SAMPLE_WIDTH-1]}},
			sample_a[SAMPLE_WIDTH-1:0]};
		b_ext    = {{(EXT_W - SAMPLE_WIDTH){sample_b[SAMPLE_WIDTH-1]}},
			sample_b[SAMPLE_WIDTH-1:0]};
		low_ext  = {range_low_q[fsr_pkg::DATA_W-1], range_low_q};
		high_ext = {range_high_q[fsr_pkg::DATA_W-1], range_high_q};
		a_cl     = (a_ext < low_ext) ? low_ext : a_ext;
		a_cl     = (a_cl > high_ext) ? high_ext : a_cl;
		b_cl     = (b_ext < low_ext) ? low_ext : b_ext;
		b_cl     = (b_cl > high_ext) ? high_ext : b_cl;
		lo_v     = (a_cl < b_cl) ? a_cl : b_cl;
		hi_v     = (a_cl < b_cl) ? b_cl : a_cl;
		dif_small = {high_ext[EXT_W-1], high_ext} - {lo_v[EXT_W-1], lo_v};
		dif_large = {high_ext[EXT_W-1], high_ext} - {hi_v[EXT_W-1], hi_v};
	end

	// stage one: complements against range_high, never negative
	always_ff @(posedge clk) begin
		if (cmd.load_s1) begin
			comp_small_s1 <= dif_small[fsr_pkg::COMP_W-1:0];
			comp_large_s1 <= dif_large[fsr_pkg::COMP_W-1:0];
		end
	end

	// saturating accumulation
	assign add_small = ADD_W'(sum_small_q) + ADD_W'(comp_small_s1);
	assign add_large = ADD_W'(sum_large_q) + ADD_W'(comp_large_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_small_q <= '0;
			sum_large_q <= '0;
		end else if (cmd.div_load) begin
			sum_small_q <= '0;
			sum_large_q <= '0;
		end else if (cmd.acc) begin
			sum_small_q <= (add_small > SUM_MAX) ? SUM_MAX[SUM_W-1:0] : add_small[SUM_W-1:0];
			sum_large_q <= (add_large > SUM_MAX) ? SUM_MAX[SUM_W-1:0] : add_large[SUM_W-1:0];
		end
	end

	// restoring divider step
	assign rem_sh  = {rem_q, 1'b0};
	assign rem_ge  = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			rem_q  <= sum_large_q;
			den_q  <= sum_small_q;
			quot_q <= '0;
			one_q  <= sum_large_q >= sum_small_q;
			zero_q <= sum_small_q == '0;
		end else if (cmd.div_step) begin
			rem_q  <= rem_ge ? rem_sub[SUM_W-1:0] : rem_q << 1;
			quot_q <= {quot_q[fsr_pkg::Q_FRAC-2:0], rem_ge};
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			zero_out_q <= zero_q;
			if (zero_q) begin
				sim_q <= '0;
			end else if (one_q) begin
				sim_q <= fsr_pkg::Q_ONE;
			end else begin
				sim_q <= {1'b0, quot_q};
			end
		end
	end

	assign similarity       = sim_q;
	assign zero_denominator = zero_out_q;

endmodule

// File: rtl/field_similarity_ratio.sv
// Field similarity ratio block: weighted Jaccard style ratio of two sample
// fields. Sample pairs enter on the s_ stream, one result per run leaves on
// the m_ stream; s_tlast marks the last pair of a run.
// Range registers are written through cfg_we / cfg_index / cfg_wdata:
// index 0 is range_low, index 1 is range_high (reset 0 and 255).
// Each sample is clamped into the range; the block sums range_high minus
// the larger and minus the smaller sample and, at the end of a run, emits
// larger-sum / smaller-sum as unsigned Q1.16 (0x10000 is 1.0).
// Throughput: one pair per cycle inside a run. After the last pair the
// input stalls while the block finishes the sum, loads the divider, runs
// the bit-serial restoring divider (one quotient bit per cycle) and loads
// the result register.
// The result register lets the next run start while the result waits; if
// the receiver still holds the previous result when a new one is ready,
// the block waits with s_tready low until it is taken.
// Reset clears the sums and both valid flags and sets the range registers to 0 and 255.
// depends on fsr_pkg, fsr_ctrl, fsr_dp
module field_similarity_ratio #(
	parameter int SAMPLE_WIDTH     = fsr_pkg::SAMPLE_WIDTH_DEF,
	parameter int LOG2_MAX_SAMPLES = fsr_pkg::LOG2_MAX_SAMPLES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [fsr_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [fsr_pkg::DATA_W-1:0]        cfg_wdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [fsr_pkg::S_TDATA_W-1:0]     s_tdata,   // sample_a, sample_b
	input  logic                              s_tlast,   // last_pair
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [fsr_pkg::M_TDATA_W-1:0]     m_tdata    // similarity, zero_denominator, pad
);

	fsr_pkg::cmd_t              cmd;
	logic [fsr_pkg::SIM_W-1:0]  similarity;
	logic                       zero_denominator;

	// controller
	fsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.cmd      (cmd)
	);

	// datapath
	fsr_dp #(
		.SAMPLE_WIDTH     (SAMPLE_WIDTH),
		.LOG2_MAX_SAMPLES (LOG2_MAX_SAMPLES)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.sample_a         (s_tdata[fsr_pkg::DATA_W-1:0]),
		.sample_b         (s_tdata[fsr_pkg::S_TDATA_W-1:fsr_pkg::DATA_W]),
		.similarity       (similarity),
		.zero_denominator (zero_denominator)
	);

	// result packing
	assign m_tdata = {{(fsr_pkg::M_TDATA_W - fsr_pkg::SIM_W - 1){1'b0}},
		zero_denominator, similarity};

endmodule

// File: rtl/fsr_checker.sv
// fsr_checker: port-level assertions for field_similarity_ratio
// depends on fsr_pkg; bound to the top level at the end of this file
module fsr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          s_tlast,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [fsr_pkg::M_TDATA_W-1:0] m_tdata
);

	// a stalled result holds its data
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// input closes after the last pair of a run
	a_last_stall: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready ##1 !s_tready)
		else $error("input taken while the run is finishing");

	// zero denominator gives a zero ratio
	a_zero_ratio: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[fsr_pkg::SIM_W] |-> m_tdata[fsr_pkg::SIM_W-1:0] == '0)
		else $error("nonzero ratio with zero denominator");

	// ratio never exceeds 1.0
	a_ratio_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[fsr_pkg::Q_FRAC] |-> m_tdata[fsr_pkg::Q_FRAC-1:0] == '0)
		else $error("ratio above 1.0");

endmodule

bind field_similarity_ratio fsr_checker u_fsr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// File: test/testbench.sv
// testbench for field_similarity_ratio: streams sample pairs with random gaps and
// back-pressure, predicts each run's Q1.16 ratio and compares every result transfer
// depends on fsr_pkg and field_similarity_ratio
module testbench;
	import fsr_pkg::*;

	localparam int SUM_W = COMP_W + LOG2_MAX_SAMPLES_DEF;
	localparam longint INT_MIN = -64'sd2147483648;
	localparam longint INT_MAX = 64'sd2147483647;

	typedef struct packed {
		logic [SIM_W-1:0] sim;
		logic             zero_den;
	} ratio_t;

	// predicted ratios and the sums behind them
	class ratio_scoreboard;
		ratio_t     ratio_q[$];
		longint     low_bound;
		longint     high_bound;
		bit [63:0]  sum_small;
		bit [63:0]  sum_large;
		int         mismatches;
		int         pairs;
		int         runs;
		int         zero_den_runs;

		function new();
			low_bound = RANGE_LOW_RST;
			high_bound = RANGE_HIGH_RST;
			sum_small = 0;
			sum_large = 0;
			mismatches = 0;
			pairs = 0;
			runs = 0;
			zero_den_runs = 0;
		endfunction

		function void set_range(longint lo, longint hi);
			low_bound = lo;
			high_bound = hi;
		endfunction

		function int pending();
			return ratio_q.size();
		endfunction

		function longint clamp(longint v);
			if (v < low_bound) v = low_bound;
			if (v > high_bound) v = high_bound;
			return v;
		endfunction

		function bit [63:0] sat_add(bit [63:0] acc, bit [63:0] add);
			bit [63:0] limit;
			limit = (64'd1 << SUM_W) - 64'd1;
			return (acc + add > limit) ? limit : acc + add;
		endfunction

		// accumulate one accepted pair, push a ratio when it closes a run
		function void note_pair(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b, logic last);
			longint    ca;
			longint    cb;
			longint    smaller;
			longint    larger;
			bit [63:0] comp_small;
			bit [63:0] comp_large;
			bit [79:0] scaled;
			ratio_t    r;
			ca = clamp($signed(a));
			cb = clamp($signed(b));
			smaller = (ca < cb) ? ca : cb;
			larger = (ca < cb) ? cb : ca;
			comp_small = (high_bound >= smaller) ? high_bound - smaller : 0;
			comp_large = (high_bound >= larger) ? high_bound - larger : 0;
			sum_small = sat_add(sum_small, comp_small);
			sum_large = sat_add(sum_large, comp_large);
			pairs++;
			if (!last)
				return;
			runs++;
			if (sum_small == 0) begin
				r.sim = '0;
				r.zero_den = 1'b1;
				zero_den_runs++;
			end else if (sum_large >= sum_small) begin
				r.sim = Q_ONE;
				r.zero_den = 1'b0;
			end else begin
				scaled = sum_large;
				scaled = scaled << Q_FRAC;
				scaled = scaled / sum_small;
				r.sim = scaled[SIM_W-1:0];
				r.zero_den = 1'b0;
			end
			ratio_q.push_back(r);
			sum_small = 0;
			sum_large = 0;
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch at %0t: %s", $realtime, msg);
		endfunction

		// compare one result transfer with the oldest prediction
		function void check_result(logic [M_TDATA_W-1:0] data);
			ratio_t got;
			ratio_t want;
			got.sim = data[SIM_W-1:0];
			got.zero_den = data[SIM_W];
			if (ratio_q.size() == 0) begin
				flag($sformatf("unexpected result: similarity %0d zero_denominator %0b",
					got.sim, got.zero_den));
				return;
			end
			want = ratio_q.pop_front();
			if (got.sim !== want.sim)
				flag($sformatf("similarity expected %0d got %0d", want.sim, got.sim));
			if (got.zero_den !== want.zero_den)
				flag($sformatf("zero_denominator expected %0b got %0b",
					want.zero_den, got.zero_den));
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [DATA_W-1:0]      cfg_wdata;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata;   // sample_a, sample_b
	logic                   s_tlast;   // last_pair
	logic                   m_tvalid;
	logic                   m_tready;
	logic [M_TDATA_W-1:0]   m_tdata;   // similarity, zero_denominator, pad

	ratio_scoreboard board;
	longint          cur_low;
	longint          cur_high;
	bit              idle_on;
	bit              send_idle;
	int              settings_used;

	field_similarity_ratio dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		#8000000;
		$display("testbench: done, errors");
		$finish;
	end

	// result side: random stall bursts, check every transfer
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				board.check_result(m_tdata);
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 12);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// one pair transfer, with an optional idle burst ahead of it
	task automatic send_pair(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b,
		input logic last);
		int gap;
		if (send_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 13);
			s_tvalid <= 1'b0;
			s_tdata <= {$urandom(), $urandom()};
			s_tlast <= 1'($urandom_range(0, 1));
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {b, a};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		board.note_pair(a, b, last);
	endtask

	// let every predicted ratio arrive, then allow the divider to settle
	task automatic drain_pipeline();
		s_tvalid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (25) @(posedge clk);
	endtask

	// write both range registers while the block is idle
	task automatic program_range(input longint lo, input longint hi);
		drain_pipeline();
		cfg_we <= 1'b1;
		cfg_index <= REG_RANGE_LOW;
		cfg_wdata <= lo[DATA_W-1:0];
		@(posedge clk);
		cfg_index <= REG_RANGE_HIGH;
		cfg_wdata <= hi[DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_range(lo, hi);
		cur_low = lo;
		cur_high = hi;
		settings_used++;
	endtask

	// mostly in range, some at or just past the ends, some anywhere
	function automatic logic [DATA_W-1:0] pick_sample();
		longint          span;
		longint          v;
		longint unsigned r;
		span = cur_high - cur_low;
		r = {$urandom(), $urandom()};
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: begin
				if (span >= 0)
					v = cur_low + longint'(r % longint'(span + 1));
				else
					v = r;
			end
			6, 7: v = r;
			8: v = $urandom_range(0, 1) ? cur_low : cur_high;
			default: v = $urandom_range(0, 1) ? cur_low - 1 : cur_high + 1;
		endcase
		return v[DATA_W-1:0];
	endfunction

	// one complete run of random pairs
	task automatic send_run(input int len);
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		send_idle = idle_on && ($urandom_range(0, 3) != 0);
		for (int i = 0; i < len; i++) begin
			a = pick_sample();
			b = ($urandom_range(0, 7) == 0) ? a : pick_sample();
			send_pair(a, b, i == len - 1);
		end
	endtask

	initial begin : stimulus
		int     sent;
		int     len;
		longint lo;
		longint hi;
		longint t;
		board = new();
		cur_low = RANGE_LOW_RST;
		cur_high = RANGE_HIGH_RST;
		settings_used = 0;
		idle_on = 1'b1;
		send_idle = 1'b1;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_RANGE_LOW;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset range 0..255: ratio of one, zero denominator, full clamp, a longer run
		send_pair(32'd0, 32'd0, 1'b1);
		send_pair(32'd255, 32'd255, 1'b1);
		send_pair(INT_MIN[31:0], INT_MAX[31:0], 1'b1);
		send_pair(32'd10, 32'd200, 1'b0);
		send_pair(32'd300, -32'sd5, 1'b0);
		send_pair(32'd128, 32'd128, 1'b1);
		send_pair(32'd100, 32'd50, 1'b1);

		// widest range: complements reach 2^32 - 1
		program_range(INT_MIN, INT_MAX);
		send_pair(INT_MIN[31:0], INT_MAX[31:0], 1'b1);
		send_pair(INT_MIN[31:0], INT_MIN[31:0], 1'b0);
		send_pair(INT_MIN[31:0], INT_MIN[31:0], 1'b1);
		send_pair(INT_MAX[31:0], INT_MAX[31:0], 1'b1);
		send_pair(32'd0, 32'hffff_ffff, 1'b1);

		// single-value range gives a zero denominator
		program_range(7, 7);
		send_pair(32'd0, 32'd100, 1'b1);
		send_pair(32'd7, 32'd7, 1'b1);

		// inverted range clamps everything to the upper end
		program_range(10, -10);
		send_pair(32'd0, 32'd5, 1'b0);
		send_pair(-32'sd20, 32'd20, 1'b1);

		// narrow signed range
		program_range(-100, 100);
		send_pair(-32'sd1, 32'd1, 1'b1);
		send_pair(-32'sd200, 32'd200, 1'b1);
		send_pair(32'd100, -32'sd100, 1'b1);

		// random runs over a sequence of range settings
		for (int p = 0; p < 10; p++) begin
			case (p)
				0: begin lo = 0; hi = 255; end
				1: begin lo = INT_MIN; hi = INT_MAX; end
				2: begin lo = -1000; hi = 1000; end
				3: begin lo = INT_MIN; hi = INT_MIN + 7; end
				4: begin lo = INT_MAX - 7; hi = INT_MAX; end
				5: begin lo = 42; hi = 42; end
				6: begin lo = 500; hi = -500; end
				default: begin
					lo = $signed($urandom());
					hi = $signed($urandom());
					if (lo > hi && $urandom_range(0, 7) != 0) begin
						t = lo;
						lo = hi;
						hi = t;
					end
				end
			endcase
			program_range(lo, hi);
			idle_on = (p < 8);
			sent = 0;
			while (sent < 175) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
					: $urandom_range(1, 10);
				send_run(len);
				sent += len;
			end
		end

		drain_pipeline();
		$display("testbench: %0d sample pairs in %0d runs over %0d range settings",
			board.pairs, board.runs, settings_used);
		$display("testbench: %0d runs had a zero denominator, %0d mismatches",
			board.zero_den_runs, board.mismatches);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

// File: files.f
rtl/fsr_pkg.sv
rtl/fsr_ctrl.sv
rtl/fsr_dp.sv
rtl/field_similarity_ratio.sv
rtl/fsr_checker.sv
test/testbench.sv
